FILE: rtl/uert_pkg.sv
// Package for the ultrasonic echo range timer.
// Holds the beat types, status and register codes and the fixed-point constants.
// No dependencies.
`default_nettype none

package uert_pkg;

  localparam int WaitW = 20;
  localparam int RangeW = 16;
  localparam int DistW = 10;
  localparam int HalfW = 15;
  localparam int StatusW = 2;
  localparam int CfgIdxW = 2;
  localparam int CfgDataW = 20;
  localparam int ScaleW = 11;
  localparam int ProdW = HalfW + ScaleW;

  localparam logic [ScaleW-1:0] CM_PER_HALF_TICK_Q16 = 11'd1114;
  localparam logic [DistW-1:0] MAX_DISTANCE_CM = 10'd556;

  localparam logic [StatusW-1:0] STATUS_MEASURED = 2'd0;
  localparam logic [StatusW-1:0] STATUS_SENSOR_ERROR = 2'd1;
  localparam logic [StatusW-1:0] STATUS_NO_OBSTACLE = 2'd2;

  localparam logic [CfgIdxW-1:0] REG_WAIT_LIMIT = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_RANGE_LIMIT = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_NEAR_THRESHOLD = 2'd2;

  localparam logic [WaitW-1:0] WAIT_LIMIT_RESET = 20'd600000;
  localparam logic [RangeW-1:0] RANGE_LIMIT_RESET = 16'd60000;
  localparam logic [DistW-1:0] NEAR_THRESHOLD_RESET = 10'd50;

  typedef struct packed {
    logic cmd;
    logic echo_level;
  } in_beat_t;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [HalfW-1:0] half_width;
    logic [DistW-1:0] distance_cm;
    logic obstacle;
  } out_beat_t;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [HalfW-1:0] half_width;
  } raw_res_t;

endpackage

`default_nettype wire

FILE: rtl/uert_ctrl.sv
// Measurement sequencer: phase and tick counters, updated once per accepted beat.
// Registers the raw status and half count of a finished measurement. Uses uert_pkg.
`default_nettype none

module uert_ctrl (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_take,
  input  wire uert_pkg::in_beat_t          in_beat,
  input  wire logic [uert_pkg::WaitW-1:0]  wait_limit,
  input  wire logic [uert_pkg::RangeW-1:0] range_limit,
  input  wire logic                        raw_take,
  output logic                             raw_valid,
  output uert_pkg::raw_res_t               raw_res
);
  import uert_pkg::*;

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_WAIT = 2'd1;
  localparam logic [1:0] PH_MEAS = 2'd2;

  logic [1:0] phase_r, phase_nxt;
  logic [WaitW-1:0] wait_count_r, wait_count_nxt, wait_inc;
  logic [RangeW-1:0] high_count_r, high_count_nxt;
  logic [RangeW:0] high_inc;
  logic res_vld;
  raw_res_t res;
  logic raw_valid_r, raw_valid_nxt;
  raw_res_t raw_res_r;

  assign wait_inc = wait_count_r + 1'b1;
  assign high_inc = {1'b0, high_count_r} + 1'b1;

  always_comb begin
    phase_nxt = phase_r;
    wait_count_nxt = wait_count_r;
    high_count_nxt = high_count_r;
    res_vld = 1'b0;
    res.status = STATUS_MEASURED;
    res.half_width = '0;
    if (in_take) begin
      if (in_beat.cmd) begin
        phase_nxt = PH_WAIT;
        wait_count_nxt = '0;
        high_count_nxt = '0;
      end else begin
        unique case (phase_r)
          PH_WAIT: begin
            if (in_beat.echo_level) begin
              phase_nxt = PH_MEAS;
              high_count_nxt = '0;
            end else begin
              wait_count_nxt = wait_inc;
              if (wait_inc >= wait_limit || wait_inc == '0) begin
                res_vld = 1'b1;
                res.status = STATUS_SENSOR_ERROR;
                phase_nxt = PH_IDLE;
              end
            end
          end
          PH_MEAS: begin
            if (in_beat.echo_level) begin
              if (high_inc > {1'b0, range_limit}) begin
                res_vld = 1'b1;
                res.status = STATUS_NO_OBSTACLE;
                phase_nxt = PH_IDLE;
              end else begin
                high_count_nxt = high_inc[RangeW-1:0];
              end
            end else begin
              res_vld = 1'b1;
              res.status = STATUS_MEASURED;
              res.half_width = high_count_r[RangeW-1:1];
              phase_nxt = PH_IDLE;
            end
          end
          default: begin
            phase_nxt = phase_r;
          end
        endcase
      end
    end
  end

  always_comb begin
    raw_valid_nxt = raw_valid_r;
    if (res_vld) begin
      raw_valid_nxt = 1'b1;
    end else if (raw_take) begin
      raw_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      wait_count_r <= '0;
      high_count_r <= '0;
      raw_valid_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      wait_count_r <= wait_count_nxt;
      high_count_r <= high_count_nxt;
      raw_valid_r <= raw_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_vld) begin
      raw_res_r <= res;
    end
  end

  assign raw_valid = raw_valid_r;
  assign raw_res = raw_res_r;

endmodule

`default_nettype wire

FILE: rtl/uert_scale.sv
// Result stage: converts the half count to centimeters and sets the near flag.
// Holds the output register and its handshake. Uses uert_pkg.
`default_nettype none

module uert_scale (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       raw_valid,
  input  wire uert_pkg::raw_res_t         raw_res,
  input  wire logic [uert_pkg::DistW-1:0] near_threshold_cm,
  output logic                            raw_take,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output uert_pkg::out_beat_t             out_data
);
  import uert_pkg::*;

  logic out_valid_r;
  out_beat_t out_data_r;
  out_beat_t beat;
  logic [ProdW-1:0] prod;

  assign raw_take = raw_valid && (!out_valid_r || !out_stall);
  assign prod = ProdW'(raw_res.half_width) * ProdW'(CM_PER_HALF_TICK_Q16);

  always_comb begin
    beat.status = raw_res.status;
    beat.half_width = '0;
    beat.distance_cm = '0;
    beat.obstacle = 1'b0;
    if (raw_res.status == STATUS_MEASURED) begin
      beat.half_width = raw_res.half_width;
      beat.distance_cm = prod[ProdW-1:16];
      beat.obstacle = (prod[ProdW-1:16] < near_threshold_cm);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (raw_take) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (raw_take) begin
      out_data_r <= beat;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data = out_data_r;

endmodule

`default_nettype wire

FILE: rtl/ultrasonic_echo_range_timer_unit.sv
// Ultrasonic echo range timer, top level: configuration registers and the two stages.
// Depends on uert_pkg, uert_ctrl and uert_scale.
//
// One input beat is taken per clock unless in_stall is high: a start beat arms the timer, and each
// tick beat samples the echo line. A finished measurement passes through the sequencer result
// register and then the output register to the result channel, and the block keeps accepting
// beats while a result waits. The input stalls only while both result registers are full and
// the output is stalled. The centimeter multiply is registered; configuration writes are always ready.
`default_nettype none

module ultrasonic_echo_range_timer_unit (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire uert_pkg::in_beat_t            in_data,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output uert_pkg::out_beat_t                out_data,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [uert_pkg::CfgIdxW-1:0]  cfg_index,
  input  wire logic [uert_pkg::CfgDataW-1:0] cfg_data
);
  import uert_pkg::*;

  logic [WaitW-1:0] wait_limit_r;
  logic [RangeW-1:0] range_limit_r;
  logic [DistW-1:0] near_threshold_r;
  logic in_take;
  logic raw_valid;
  logic raw_take;
  raw_res_t raw_res;

  assign cfg_ready = 1'b1;
  assign in_stall = raw_valid && !raw_take;
  assign in_take = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wait_limit_r <= WAIT_LIMIT_RESET;
      range_limit_r <= RANGE_LIMIT_RESET;
      near_threshold_r <= NEAR_THRESHOLD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_WAIT_LIMIT: wait_limit_r <= cfg_data[WaitW-1:0];
        REG_RANGE_LIMIT: range_limit_r <= cfg_data[RangeW-1:0];
        REG_NEAR_THRESHOLD: near_threshold_r <= cfg_data[DistW-1:0];
        default: begin
        end
      endcase
    end
  end

  uert_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_take    (in_take),
    .in_beat    (in_data),
    .wait_limit (wait_limit_r),
    .range_limit(range_limit_r),
    .raw_take   (raw_take),
    .raw_valid  (raw_valid),
    .raw_res    (raw_res)
  );

  uert_scale u_scale (
    .clk              (clk),
    .rst_n            (rst_n),
    .raw_valid        (raw_valid),
    .raw_res          (raw_res),
    .near_threshold_cm(near_threshold_r),
    .raw_take         (raw_take),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_data         (out_data)
  );

endmodule

`default_nettype wire

FILE: rtl/uert_checker.sv
// Port-level checks for the ultrasonic echo range timer, bound to its top level.
// Depends on uert_pkg.
`default_nettype none

module uert_checker (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                out_valid,
  input wire logic                out_stall,
  input wire uert_pkg::out_beat_t out_data
);
  import uert_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("Stalled result beat changed.");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != STATUS_MEASURED |->
      out_data.half_width == '0 && out_data.distance_cm == '0 && !out_data.obstacle)
    else $error("Error or no-obstacle beat carries a measurement.");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.status == STATUS_MEASURED ||
      out_data.status == STATUS_SENSOR_ERROR || out_data.status == STATUS_NO_OBSTACLE)
    else $error("Result beat has an unused status code.");

  a_dist_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == STATUS_MEASURED |-> out_data.distance_cm <= MAX_DISTANCE_CM)
    else $error("Distance exceeds the largest possible value.");

endmodule

bind ultrasonic_echo_range_timer_unit uert_checker u_uert_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_data (out_data)
);

`default_nettype wire

FILE: tb/ultrasonic_echo_range_timer_unit_tb.sv
// Self-checking testbench for ultrasonic_echo_range_timer_unit: directed, full-scale,
// backpressure and random echo traffic, checked against a local range predictor.
// Depends on uert_pkg and the RTL of the unit.
module ultrasonic_echo_range_timer_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import uert_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned SETTLE_CYCLES = 6;
  localparam int unsigned END_CYCLES = 20;
  localparam int unsigned HOLDOFF_CYCLES = 300;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_WAIT = 2'd1,
    PH_MEASURE = 2'd2
  } echo_phase_e;

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_beat_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_beat_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CfgIdxW-1:0] cfg_index = REG_WAIT_LIMIT;
  logic [CfgDataW-1:0] cfg_data = '0;

  echo_phase_e echo_phase = PH_IDLE;
  logic [WaitW-1:0] wait_cnt = '0;
  logic [RangeW-1:0] high_cnt = '0;
  logic [WaitW-1:0] wait_lim = WAIT_LIMIT_RESET;
  logic [RangeW-1:0] range_lim = RANGE_LIMIT_RESET;
  logic [DistW-1:0] near_thr = NEAR_THRESHOLD_RESET;

  out_beat_t range_result_q[$];
  out_beat_t want_beat;

  int unsigned beats_sent = 0;
  int unsigned beats_effective = 0;
  int unsigned results_due = 0;
  int unsigned results_seen = 0;
  int unsigned n_measured = 0;
  int unsigned n_sensor_error = 0;
  int unsigned n_no_obstacle = 0;
  int unsigned n_near = 0;
  int unsigned mismatches = 0;
  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned holdoff_left = 0;
  int unsigned quiet_cycles = 0;

  ultrasonic_echo_range_timer_unit dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic bit predict_echo(input in_beat_t b, output out_beat_t r,
                                      output bit effective);
    logic [RangeW:0] next_high;
    logic [HalfW-1:0] half;
    logic [ProdW-1:0] prod;
    r = '0;
    effective = 1'b1;
    predict_echo = 1'b0;
    if (b.cmd) begin
      echo_phase = PH_WAIT;
      wait_cnt = '0;
      high_cnt = '0;
    end else if (echo_phase == PH_WAIT) begin
      if (b.echo_level) begin
        echo_phase = PH_MEASURE;
        high_cnt = '0;
      end else begin
        wait_cnt = wait_cnt + 1'b1;
        if (wait_cnt >= wait_lim || wait_cnt == '0) begin
          r.status = STATUS_SENSOR_ERROR;
          echo_phase = PH_IDLE;
          predict_echo = 1'b1;
        end
      end
    end else if (echo_phase == PH_MEASURE) begin
      if (b.echo_level) begin
        next_high = {1'b0, high_cnt} + 1'b1;
        if (next_high > {1'b0, range_lim}) begin
          r.status = STATUS_NO_OBSTACLE;
          echo_phase = PH_IDLE;
          predict_echo = 1'b1;
        end else begin
          high_cnt = next_high[RangeW-1:0];
        end
      end else begin
        half = high_cnt[RangeW-1:1];
        prod = ProdW'(half) * ProdW'(CM_PER_HALF_TICK_Q16);
        r.status = STATUS_MEASURED;
        r.half_width = half;
        r.distance_cm = prod[ProdW-1:16];
        r.obstacle = (r.distance_cm < near_thr);
        echo_phase = PH_IDLE;
        predict_echo = 1'b1;
      end
    end else begin
      effective = 1'b0;
    end
  endfunction

  function automatic void log_mismatch(input string what, input out_beat_t want,
                                       input out_beat_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t %s: expected status %0d half %0d dist %0d near %0d, got %0d %0d %0d %0d",
               $time, what, want.status, want.half_width, want.distance_cm, want.obstacle,
               got.status, got.half_width, got.distance_cm, got.obstacle);
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (range_result_q.size() == 0) begin
        log_mismatch("result with nothing expected", '0, out_data);
      end else begin
        want_beat = range_result_q.pop_front();
        if (out_data.status !== want_beat.status ||
            out_data.half_width !== want_beat.half_width ||
            out_data.distance_cm !== want_beat.distance_cm ||
            out_data.obstacle !== want_beat.obstacle) begin
          log_mismatch("result field mismatch", want_beat, out_data);
        end
      end
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if (holdoff_left > 0) begin
        out_stall <= 1'b1;
        holdoff_left--;
      end else begin
        out_stall <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Timeout after %0d quiet cycles, %0d results outstanding.",
               quiet_cycles, range_result_q.size());
      $display("ultrasonic_echo_range_timer_unit: mismatch");
      $finish;
    end
  end

  task automatic send_beat(input logic cmd, input logic echo);
    in_beat_t b;
    out_beat_t r;
    bit effective;
    b.cmd = cmd;
    b.echo_level = echo;
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= b;
    do @(posedge clk); while (in_stall);
    beats_sent++;
    if (predict_echo(b, r, effective)) begin
      range_result_q.push_back(r);
      results_due++;
      case (r.status)
        STATUS_MEASURED: n_measured++;
        STATUS_SENSOR_ERROR: n_sensor_error++;
        default: n_no_obstacle++;
      endcase
      if (r.obstacle) n_near++;
    end
    if (effective) beats_effective++;
  endtask

  task automatic settle_block();
    in_valid <= 1'b0;
    while (range_result_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic close_measurement();
    while (echo_phase != PH_IDLE) send_beat(1'b0, echo_phase == PH_WAIT);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    close_measurement();
    settle_block();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_WAIT_LIMIT: wait_lim = val[WaitW-1:0];
      REG_RANGE_LIMIT: range_lim = val[RangeW-1:0];
      REG_NEAR_THRESHOLD: near_thr = val[DistW-1:0];
      default: ;
    endcase
  endtask

  task automatic drive_echo_sequences(input int unsigned beat_goal,
                                      input int unsigned result_goal);
    int unsigned beats0;
    int unsigned results0;
    int unsigned kind;
    int unsigned n;
    beats0 = beats_effective;
    results0 = results_due;
    while (beats_effective - beats0 < beat_goal || results_due - results0 < result_goal) begin
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
        repeat ($urandom_range(1, 6)) begin
          send_beat(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end
      end else begin
        send_beat(1'b1, 1'($urandom_range(0, 1)));
        n = ($urandom_range(0, 4) == 0) ? 32'(wait_lim) : $urandom_range(0, wait_lim);
        repeat (n) send_beat(1'b0, 1'b0);
        if (kind != 1 && echo_phase == PH_WAIT) begin
          send_beat(1'b0, 1'b1);
          case ($urandom_range(0, 4))
            0: n = 32'(range_lim) + 1;
            1: n = 32'(range_lim);
            default: n = $urandom_range(0, range_lim);
          endcase
          repeat (n) send_beat(1'b0, 1'b1);
          if (kind != 2) send_beat(1'b0, 1'b0);
        end
      end
    end
  endtask

  task automatic test_default_measure();
    idle_pct = 0;
    stall_pct = 0;
    send_beat(1'b0, 1'b0);
    send_beat(1'b0, 1'b1);
    send_beat(1'b1, 1'b1);
    send_beat(1'b0, 1'b0);
    send_beat(1'b0, 1'b1);
    send_beat(1'b0, 1'b1);
    send_beat(1'b0, 1'b1);
    send_beat(1'b0, 1'b0);
  endtask

  task automatic test_restart_while_busy();
    send_beat(1'b1, 1'b0);
    send_beat(1'b0, 1'b1);
    send_beat(1'b0, 1'b1);
    send_beat(1'b1, 1'b0);
    send_beat(1'b0, 1'b0);
    send_beat(1'b0, 1'b1);
    send_beat(1'b0, 1'b0);
  endtask

  task automatic test_wait_timeout();
    write_reg(REG_WAIT_LIMIT, 20'd1);
    send_beat(1'b1, 1'b0);
    send_beat(1'b0, 1'b0);
    write_reg(REG_WAIT_LIMIT, 20'd0);
    send_beat(1'b1, 1'b1);
    send_beat(1'b0, 1'b0);
  endtask

  task automatic test_range_overflow();
    write_reg(REG_RANGE_LIMIT, 20'd1);
    send_beat(1'b1, 1'b0);
    send_beat(1'b0, 1'b1);
    send_beat(1'b0, 1'b1);
    send_beat(1'b0, 1'b1);
    send_beat(1'b0, 1'b0);
  endtask

  task automatic test_near_flag();
    write_reg(REG_NEAR_THRESHOLD, 20'd0);
    send_beat(1'b1, 1'b0);
    send_beat(1'b0, 1'b1);
    send_beat(1'b0, 1'b0);
    write_reg(REG_NEAR_THRESHOLD, 20'd1023);
    send_beat(1'b1, 1'b0);
    send_beat(1'b0, 1'b1);
    send_beat(1'b0, 1'b1);
    send_beat(1'b0, 1'b0);
  endtask

  task automatic test_random_traffic();
    int unsigned sender_idle[4] = '{0, 50, 0, 34};
    int unsigned receiver_stall[4] = '{0, 0, 50, 34};
    int unsigned thr;
    for (int mode = 0; mode < 4; mode++) begin
      idle_pct = sender_idle[mode];
      stall_pct = receiver_stall[mode];
      case ($urandom_range(0, 2))
        0: thr = 0;
        1: thr = 1;
        default: thr = $urandom_range(0, 1023);
      endcase
      write_reg(REG_WAIT_LIMIT, CfgDataW'($urandom_range(1, 12)));
      write_reg(REG_RANGE_LIMIT, CfgDataW'($urandom_range(1, 30)));
      write_reg(REG_NEAR_THRESHOLD, CfgDataW'(thr));
      drive_echo_sequences(70, 6);
      if (mode == 0 || mode == 3) begin
        write_reg(REG_WAIT_LIMIT, CfgDataW'($urandom_range(4, 12)));
        write_reg(REG_RANGE_LIMIT, CfgDataW'($urandom_range(118, 140)));
        write_reg(REG_NEAR_THRESHOLD, CfgDataW'($urandom_range(0, 4)));
        drive_echo_sequences(30, 2);
      end
    end
  endtask

  task automatic test_backpressure();
    idle_pct = 0;
    stall_pct = 0;
    write_reg(REG_WAIT_LIMIT, 20'd1);
    holdoff_left = HOLDOFF_CYCLES;
    repeat (40) begin
      send_beat(1'b1, 1'b0);
      send_beat(1'b0, 1'b0);
    end
    settle_block();
  endtask

  task automatic test_full_scale();
    idle_pct = 0;
    stall_pct = 0;
    write_reg(REG_WAIT_LIMIT, 20'hFFFFF);
    write_reg(REG_RANGE_LIMIT, 20'h0FFFF);
    write_reg(REG_NEAR_THRESHOLD, 20'h003FF);
    send_beat(1'b1, 1'b1);
    repeat (5) send_beat(1'b0, 1'b0);
    send_beat(1'b0, 1'b1);
    repeat (121) send_beat(1'b0, 1'b1);
    send_beat(1'b0, 1'b0);
    send_beat(1'b1, 1'b0);
    send_beat(1'b0, 1'b1);
    repeat (20) send_beat(1'b0, 1'b1);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_default_measure();
    test_restart_while_busy();
    test_wait_timeout();
    test_range_overflow();
    test_near_flag();
    test_random_traffic();
    test_backpressure();
    test_full_scale();
    close_measurement();
    settle_block();
    repeat (END_CYCLES) @(posedge clk);
    $display("Sent %0d beats (%0d acted on) across four idle/stall mixes and full-scale limits.",
             beats_sent, beats_effective);
    $display("Checked %0d results: %0d measured, %0d sensor errors, %0d no obstacle, %0d near.",
             results_seen, n_measured, n_sensor_error, n_no_obstacle, n_near);
    if (mismatches == 0 && range_result_q.size() == 0) begin
      $display("ultrasonic_echo_range_timer_unit: match");
    end else begin
      $display("ultrasonic_echo_range_timer_unit: mismatch");
    end
    $finish;
  end

endmodule
